// ===== src/pdad_pkg.sv =====
// ---------------------------------------------------------------------------
// pdad_pkg: shared types and constants for the pose delta block
// Holds the controller-to-datapath command, the multiply schedule step
// names and the arctangent table used by the CORDIC unit.
// ---------------------------------------------------------------------------
package pdad_pkg;

   // Widths of the payload fields
   localparam int FRAME_W = 31;
   localparam int POS_W   = 32;
   localparam int QUAT_W  = 16;
   localparam int AXIS_W  = 17;
   localparam int ANGLE_W = 15;
   localparam int DIST_W  = 32;
   localparam int ITER_W  = 5;

   // Steps of the multiply schedule
   localparam logic [ITER_W-1:0] STEP_XZ     = 5'd0;
   localparam logic [ITER_W-1:0] STEP_WY     = 5'd1;
   localparam logic [ITER_W-1:0] STEP_YZ     = 5'd2;
   localparam logic [ITER_W-1:0] STEP_WX     = 5'd3;
   localparam logic [ITER_W-1:0] STEP_XX     = 5'd4;
   localparam logic [ITER_W-1:0] STEP_YY     = 5'd5;
   localparam logic [ITER_W-1:0] STEP_YY_ACC = 5'd6;
   localparam logic [ITER_W-1:0] STEP_AXIS   = 5'd7;
   localparam logic [ITER_W-1:0] STEP_DOT_X  = 5'd8;
   localparam logic [ITER_W-1:0] STEP_DOT_Y  = 5'd9;
   localparam logic [ITER_W-1:0] STEP_DOT_Z  = 5'd10;
   localparam logic [ITER_W-1:0] STEP_DOT_E  = 5'd11;
   localparam logic [ITER_W-1:0] STEP_CLAMP  = 5'd12;
   localparam logic [ITER_W-1:0] STEP_COMMIT = 5'd13;
   localparam logic [ITER_W-1:0] STEP_ROOT   = 5'd14;
   localparam logic [ITER_W-1:0] ITER_LAST   = 5'd31;

   // Fixed point constants
   localparam logic signed [33:0] PI_HALF_Q30 = 34'sd1686629713;
   localparam logic [16:0]        ANGLE_MAX   = 17'd25736;
   localparam logic [3:0]         KEEP_RESET  = 4'd3;

   // Command word from the controller to the datapath
   typedef struct packed {
      logic              in_load;
      logic              mul_en;
      logic              arc_load;
      logic              sqrt_step;
      logic              arc_step;
      logic              out_load;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   // Arctangent of 2^-i in Q.30, truncated
   function automatic logic [30:0] atan_q30(input logic [ITER_W-1:0] i);
      logic [30:0] r;
      begin
         case (i)
            5'd0: r = 31'd843314856;
            5'd1: r = 31'd497837829;
            5'd2: r = 31'd263043836;
            5'd3: r = 31'd133525158;
            5'd4: r = 31'd67021686;
            5'd5: r = 31'd33543515;
            5'd6: r = 31'd16775850;
            5'd7: r = 31'd8388437;
            5'd8: r = 31'd4194282;
            5'd9: r = 31'd2097149;
            5'd31: r = 31'd0;
            default: r = (31'd1 << (5'd30 - i)) - 31'd1;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== src/pose_delta_angle_distance.sv =====
// ---------------------------------------------------------------------------
// pose_delta_angle_distance: tilt angle and step distance between poses
// Keeps one pose in every keep_every and reports, for each kept pose after
// the first, the angle between successive z-axes and the distance moved.
//
//   Channel  Direction  Beat contents
//   req      in         pose: frame index, position, quaternion
//   rsp      out        frame index, tilt angle, step distance
//   csr      in         keep_every register write
//
// A dropped pose only advances the keep cycle. A kept pose is taken in its
// accept cycle, then runs the multiply schedule, the square root unit for
// the angle, a setup state and the phase in which the distance root and
// CORDIC run together, then loads the result. The first kept pose after
// reset stops at the commit step of the multiply schedule. Reset is
// synchronous; req is not taken while a pose is in progress, and a held
// result stalls the load of the next one, while which no req is taken.
// ---------------------------------------------------------------------------
module pose_delta_angle_distance
   import pdad_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_index, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_frame_index, tilt_angle, step_distance
   output logic [79:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_data
);

   cmd_type cmd;

   // Sequencer
   pdad_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd)
   );

   // Arithmetic
   pdad_dp u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== src/pdad_ctrl.sv =====
// ---------------------------------------------------------------------------
// pdad_ctrl: sequencer for the pose delta block
// Keeps the keep cycle, the first-pose flag and the result valid, and steps
// the datapath through the multiply schedule, the square roots and CORDIC.
// ---------------------------------------------------------------------------
module pdad_ctrl
   import pdad_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ROOT  = 6'b000100,
      ST_SETUP = 6'b001000,
      ST_ITER  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   localparam logic [ITER_W:0] STEPS_LIM = (ITER_W+1)'(CORDIC_STEPS);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [3:0]        keep_ff, keep_in;
   logic [3:0]        phase_ff, phase_in;
   logic              have_prev_ff, have_prev_in;
   logic              valid_ff, valid_in;
   logic [3:0]        period;
   logic [4:0]        phase_inc;
   logic              accept;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign accept     = req_tvalid && req_tready;

   // Keep cycle: a zero period behaves as one
   always_comb begin
      period    = (keep_ff == 4'd0) ? 4'd1 : keep_ff;
      phase_inc = {1'b0, phase_ff} + 5'd1;
      keep_in   = (csr_valid && csr_ready) ? csr_data : keep_ff;
      phase_in  = phase_ff;
      if (accept) begin
         phase_in = (phase_inc >= {1'b0, period}) ? 4'd0 : phase_inc[3:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      have_prev_in = have_prev_ff;
      cmd          = '0;
      cmd.iter     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && phase_ff == 4'd0) begin
               cmd.in_load = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == STEP_COMMIT && !have_prev_ff) begin
               have_prev_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cnt_ff == STEP_ROOT) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == ITER_LAST) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.arc_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_ITER;
         end
         ST_ITER: begin
            cmd.sqrt_step = 1'b1;
            cmd.arc_step  = ({1'b0, cnt_ff} < STEPS_LIM);
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == ITER_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on load, cleared when the beat is taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         keep_ff      <= KEEP_RESET;
         phase_ff     <= '0;
         have_prev_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         keep_ff      <= keep_in;
         phase_ff     <= phase_in;
         have_prev_ff <= have_prev_in;
         valid_ff     <= valid_in;
      end
   end

`ifndef SYNTHESIS
   // A result is only loaded once a previous pose is known.
   a_load_needs_prev: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> have_prev_ff)
      else $error("result loaded without a previous pose");

   // A new result appears only from the output state.
   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result valid raised outside the output state");

   // The multiply schedule never runs past its last step.
   a_mul_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff <= STEP_ROOT))
      else $error("multiply schedule overran");
`endif

endmodule

// ===== src/pdad_dp.sv =====
// ---------------------------------------------------------------------------
// pdad_dp: datapath for the pose delta block
// One 17x17 and one 32x32 multiplier run a fixed schedule for the axis,
// the dot product and the squared distance; one shared square root unit
// and one CORDIC unit finish the angle and the distance.
// ---------------------------------------------------------------------------
module pdad_dp
   import pdad_pkg::*;
(
   input  logic               clock,
   input  logic [191:0]       req_tdata,
   input  cmd_type            cmd,
   output logic [79:0]        rsp_tdata
);

   // Latched pose
   logic [FRAME_W-1:0]        frame_ff;
   logic signed [POS_W-1:0]   px_ff, py_ff, pz_ff;
   logic signed [QUAT_W-1:0]  qx_ff, qy_ff, qz_ff, qw_ff;
   // Previous kept pose
   logic signed [POS_W-1:0]   ppx_ff, ppy_ff, ppz_ff;
   logic signed [AXIS_W-1:0]  pax_ff, pay_ff, paz_ff;
   // Products and accumulators
   logic signed [AXIS_W-1:0]  ax_ff, ay_ff, az_ff;
   logic signed [33:0]        sp_ff, acc_a_ff, acc_b_ff, acc_c_ff;
   logic signed [35:0]        dot_ff;
   logic signed [31:0]        d_ff;
   logic [63:0]               bp_ff;
   logic [65:0]               sum_ff;
   // Square root unit
   logic [63:0]               rem_ff, root_ff;
   logic                      dsat_ff;
   // CORDIC unit
   logic signed [33:0]        cx_ff, cy_ff, cz_ff;
   // Result register
   logic [FRAME_W-1:0]        rsp_frame_ff;
   logic [ANGLE_W-1:0]        rsp_angle_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   logic signed [AXIS_W-1:0]  sa, sb;
   logic [31:0]               ba;
   logic signed [32:0]        dx, dy, dz;
   logic [31:0]               mx, my, mz, md;
   logic signed [AXIS_W-1:0]  ax_n, ay_n, az_n;
   logic [64:0]               bit_v, trial;
   logic [5:0]                bit_sh;
   logic signed [33:0]        xs, ys, atan_v;
   logic signed [33:0]        zc;
   logic [16:0]               zr;

   assign rsp_tdata = {2'b00, rsp_dist_ff, rsp_angle_ff, rsp_frame_ff};

   // Round a Q2.30 sum to Q2.15 and saturate to 17 bits
   function automatic logic signed [AXIS_W-1:0] round_sat(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [20:0] r;
      begin
         t = {v[33], v} + 35'sd8192;
         r = t[34:14];
         if (r > 21'sd65535) begin
            return 17'sd65535;
         end else if (r < -21'sd65536) begin
            return -17'sd65536;
         end
         return r[16:0];
      end
   endfunction

   function automatic logic signed [AXIS_W-1:0] one_minus(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [21:0] r;
      begin
         t = {v[33], v} + 35'sd8192;
         r = 22'sd32768 - {t[34], t[34:14]};
         if (r > 22'sd65535) begin
            return 17'sd65535;
         end else if (r < -22'sd65536) begin
            return -17'sd65536;
         end
         return r[16:0];
      end
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      begin
         n = -v;
         return v[32] ? n[31:0] : v[31:0];
      end
   endfunction

   // Differences, magnitudes and finished axis
   always_comb begin
      dx   = {px_ff[31], px_ff} - {ppx_ff[31], ppx_ff};
      dy   = {py_ff[31], py_ff} - {ppy_ff[31], ppy_ff};
      dz   = {pz_ff[31], pz_ff} - {ppz_ff[31], ppz_ff};
      mx   = mag33(dx);
      my   = mag33(dy);
      mz   = mag33(dz);
      md   = mag33({d_ff[31], d_ff});
      ax_n = round_sat(acc_a_ff);
      ay_n = round_sat(acc_b_ff);
      az_n = one_minus(acc_c_ff);
   end

   // Operand selection for both multipliers
   always_comb begin
      sa = '0;
      sb = '0;
      ba = '0;
      case (cmd.iter)
         STEP_XZ: begin
            sa = AXIS_W'(qx_ff); sb = AXIS_W'(qz_ff); ba = mx;
         end
         STEP_WY: begin
            sa = AXIS_W'(qw_ff); sb = AXIS_W'(qy_ff); ba = my;
         end
         STEP_YZ: begin
            sa = AXIS_W'(qy_ff); sb = AXIS_W'(qz_ff); ba = mz;
         end
         STEP_WX: begin
            sa = AXIS_W'(qw_ff); sb = AXIS_W'(qx_ff);
         end
         STEP_XX: begin
            sa = AXIS_W'(qx_ff); sb = AXIS_W'(qx_ff);
         end
         STEP_YY: begin
            sa = AXIS_W'(qy_ff); sb = AXIS_W'(qy_ff);
         end
         STEP_DOT_X: begin
            sa = ax_ff; sb = pax_ff;
         end
         STEP_DOT_Y: begin
            sa = ay_ff; sb = pay_ff;
         end
         STEP_DOT_Z: begin
            sa = az_ff; sb = paz_ff;
         end
         STEP_COMMIT: begin
            ba = md;
         end
         default: begin
            sa = '0;
         end
      endcase
   end

   // Input latch
   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         frame_ff <= req_tdata[30:0];
         px_ff    <= req_tdata[62:31];
         py_ff    <= req_tdata[94:63];
         pz_ff    <= req_tdata[126:95];
         qx_ff    <= req_tdata[142:127];
         qy_ff    <= req_tdata[158:143];
         qz_ff    <= req_tdata[174:159];
         qw_ff    <= req_tdata[190:175];
      end
   end

   // Multiply schedule: products registered, then accumulated from the product register
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         sp_ff <= sa * sb;
         bp_ff <= 64'(ba) * 64'(ba);
         case (cmd.iter)
            STEP_WY:     begin acc_a_ff <= sp_ff; sum_ff <= 66'(bp_ff); end
            STEP_YZ:     begin acc_a_ff <= acc_a_ff + sp_ff; sum_ff <= sum_ff + 66'(bp_ff); end
            STEP_WX:     begin acc_b_ff <= sp_ff; sum_ff <= sum_ff + 66'(bp_ff); end
            STEP_XX:     acc_b_ff <= acc_b_ff - sp_ff;
            STEP_YY:     acc_c_ff <= sp_ff;
            STEP_YY_ACC: acc_c_ff <= acc_c_ff + sp_ff;
            STEP_AXIS: begin
               ax_ff <= ax_n;
               ay_ff <= ay_n;
               az_ff <= az_n;
            end
            STEP_DOT_Y:  dot_ff <= 36'(sp_ff);
            STEP_DOT_Z:  dot_ff <= dot_ff + 36'(sp_ff);
            STEP_DOT_E:  dot_ff <= dot_ff + 36'(sp_ff);
            STEP_CLAMP: begin
               if (dot_ff > 36'sh040000000) begin
                  d_ff <= 32'sh40000000;
               end else if (dot_ff < -36'sh040000000) begin
                  d_ff <= -32'sh40000000;
               end else begin
                  d_ff <= dot_ff[31:0];
               end
            end
            STEP_COMMIT: begin
               pax_ff <= ax_ff;
               pay_ff <= ay_ff;
               paz_ff <= az_ff;
               ppx_ff <= px_ff;
               ppy_ff <= py_ff;
               ppz_ff <= pz_ff;
            end
            default: begin
               dot_ff <= dot_ff;
            end
         endcase
      end
   end

   // Square root unit: one result bit per cycle
   always_comb begin
      bit_sh = 6'd62 - {cmd.iter, 1'b0};
      bit_v  = 65'd1 << bit_sh;
      trial  = {1'b0, root_ff} + bit_v;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en && cmd.iter == STEP_ROOT) begin
         rem_ff  <= (64'd1 << 60) - bp_ff;
         root_ff <= '0;
      end else if (cmd.arc_load) begin
         rem_ff  <= sum_ff[63:0];
         root_ff <= '0;
         dsat_ff <= |sum_ff[65:64];
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff  <= rem_ff - trial[63:0];
            root_ff <= (root_ff >> 1) + bit_v[63:0];
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   // CORDIC vectoring unit
   always_comb begin
      xs     = cx_ff >>> cmd.iter;
      ys     = cy_ff >>> cmd.iter;
      atan_v = {3'b000, atan_q30(cmd.iter)};
   end

   always_ff @(posedge clock) begin
      if (cmd.arc_load) begin
         if (d_ff[31]) begin
            cx_ff <= {2'b00, root_ff[31:0]};
            cy_ff <= -{{2{d_ff[31]}}, d_ff};
            cz_ff <= PI_HALF_Q30;
         end else begin
            cx_ff <= {{2{d_ff[31]}}, d_ff};
            cy_ff <= {2'b00, root_ff[31:0]};
            cz_ff <= '0;
         end
      end else if (cmd.arc_step) begin
         if (!cy_ff[33]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + atan_v;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - atan_v;
         end
      end
   end

   // Angle rounding to Q2.13
   always_comb begin
      zc = cz_ff[33] ? 34'sd0 : cz_ff + 34'sd65536;
      zr = zc[33:17];
      if (zr > ANGLE_MAX) begin
         zr = ANGLE_MAX;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_frame_ff <= frame_ff;
         rsp_angle_ff <= zr[14:0];
         rsp_dist_ff  <= dsat_ff ? 32'hFFFFFFFF : root_ff[31:0];
      end
   end

endmodule

// ===== sim/pose_delta_angle_distance_tb.sv =====
// ---------------------------------------------------------------------------
// pose_delta_angle_distance_tb: self-checking bench for the pose delta block
// A short table of directed poses and then random pose streams in several
// phases of keep period and flow control. Every accepted pose goes through
// an independent model of the tilt angle and step distance, and every
// result beat is compared field by field with the oldest expected result.
// ---------------------------------------------------------------------------
module pose_delta_angle_distance_tb;
   import pdad_pkg::*;

   typedef struct {
      logic [FRAME_W-1:0]       frame;
      logic signed [POS_W-1:0]  px, py, pz;
      logic signed [QUAT_W-1:0] qx, qy, qz, qw;
   } pose_type;

   typedef struct {
      logic [FRAME_W-1:0] frame;
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  step_len;
   } motion_type;

   // A directed row: a pose plus, where obvious, a typed result
   typedef struct {
      pose_type pose;
      bit       has_fixed;
      bit       fixed_out;
      logic [DIST_W-1:0] fixed_dist;
   } row_type;

   localparam int ANGLE_LIMIT = 25736;
   localparam int SETTLE      = 150;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_data = '0;

   // Model state
   longint   axis_x, axis_y, axis_z;
   longint   last_x, last_y, last_z;
   bit       seen_pose;
   int       keep_phase;
   int       keep_period_reg;

   motion_type motion_queue[$];
   int  fault_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   longint atan_q30_tab[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                33543515, 16775850, 8388437, 4194282, 2097149};

   pose_delta_angle_distance dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock of period 20.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Floor square root of a value below 2^66.
   function automatic logic [63:0] floor_root(input logic [127:0] n);
      logic [127:0] res;
      logic [127:0] bitv;
      begin
         res  = '0;
         bitv = 128'd1 << 126;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res[63:0];
      end
   endfunction

   // Rounds a Q2.30 sum to Q2.15.
   function automatic longint to_q15(input longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic longint clip17(input longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
   endfunction

   // Arccos of a Q.30 cosine by CORDIC vectoring, result in Q2.13.
   function automatic logic [ANGLE_W-1:0] tilt_of(input longint d);
      longint x, y, z, t, xs, ys, step;
      begin
         z = 0;
         x = d;
         y = longint'(floor_root(128'(64'd1 << 60) - 128'(d * d)));
         // Negative cosine: turn the vector by a quarter turn first.
         if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 1686629713;
         end
         for (int i = 0; i < 16; i++) begin
            step = (i < 10) ? atan_q30_tab[i] : ((longint'(1) << (30 - i)) - 1);
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; z = z + step;
            end else begin
               x = x - ys; y = y + xs; z = z - step;
            end
         end
         if (z < 0) z = 0;
         z = (z + 65536) >>> 17;
         if (z > ANGLE_LIMIT) z = ANGLE_LIMIT;
         return z[ANGLE_W-1:0];
      end
   endfunction

   // Advances the keep cycle for one pose and returns whether a result follows.
   function automatic bit predict_motion(input pose_type p, output motion_type m);
      int     period;
      bit     kept, made;
      longint ax, ay, az, dot, dx, dy, dz;
      logic [127:0] sum;
      logic [63:0]  root;
      begin
         made   = 1'b0;
         m      = '{default: '0};
         period = (keep_period_reg == 0) ? 1 : keep_period_reg;
         kept   = (keep_phase == 0);
         keep_phase = (keep_phase + 1 >= period) ? 0 : ((keep_phase + 1) & 15);
         if (kept) begin
            ax = clip17(to_q15(longint'(p.qx) * p.qz + longint'(p.qw) * p.qy));
            ay = clip17(to_q15(longint'(p.qy) * p.qz - longint'(p.qw) * p.qx));
            az = clip17(32768 - to_q15(longint'(p.qx) * p.qx + longint'(p.qy) * p.qy));
            if (seen_pose) begin
               dot = ax * axis_x + ay * axis_y + az * axis_z;
               if (dot > (longint'(1) << 30)) dot = longint'(1) << 30;
               if (dot < -(longint'(1) << 30)) dot = -(longint'(1) << 30);
               dx = longint'(p.px) - last_x;
               dy = longint'(p.py) - last_y;
               dz = longint'(p.pz) - last_z;
               // Squares are formed at full width; each can exceed 2^63.
               sum = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
               root = floor_root(sum);
               m.frame    = p.frame;
               m.angle    = tilt_of(dot);
               m.step_len = (sum >= (128'd1 << 64)) ? 32'hFFFF_FFFF : root[DIST_W-1:0];
               made = 1'b1;
            end
            axis_x = ax; axis_y = ay; axis_z = az;
            last_x = p.px; last_y = p.py; last_z = p.pz;
            seen_pose = 1'b1;
         end
         return made;
      end
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      fault_count++;
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= (reset == 1'b0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor: a beat seen here with both lines high is taken at the next edge.
   always @(negedge clock) begin
      motion_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame    = rsp_tdata[30:0];
         got.angle    = rsp_tdata[45:31];
         got.step_len = rsp_tdata[77:46];
         if (motion_queue.size() == 0) begin
            report("unexpected result beat, frame", got.frame, -1);
         end else begin
            want = motion_queue.pop_front();
            if (got.frame !== want.frame) report("frame index", got.frame, want.frame);
            if (got.angle !== want.angle) report("tilt angle", got.angle, want.angle);
            if (got.step_len !== want.step_len)
               report("step distance", got.step_len, want.step_len);
         end
      end
   end

   // Sends one pose, with random idle cycles first, and predicts its result.
   task automatic send_pose(input pose_type p, output bit made, output motion_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, p.qw, p.qz, p.qy, p.qx, p.pz, p.py, p.px, p.frame};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      made = predict_motion(p, m);
      if (made) motion_queue = {motion_queue, m};
   endtask

   task automatic drain_results;
      while (motion_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes keep_every while the block is idle.
   task automatic write_keep(input logic [3:0] value);
      req_tvalid <= 1'b0;
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      keep_period_reg = value;
   endtask

   // A random pose: mostly a unit rotation near a random walk, sometimes raw noise.
   function automatic pose_type random_pose(input pose_type prior);
      pose_type p;
      real half, ux, uy, uz, un, s;
      begin
         p.frame = 31'($urandom());
         if ($urandom_range(9) == 0) begin
            p.px = $urandom(); p.py = $urandom(); p.pz = $urandom();
            p.qx = 16'($urandom()); p.qy = 16'($urandom());
            p.qz = 16'($urandom()); p.qw = 16'($urandom());
         end else begin
            p.px = prior.px + $signed($urandom_range(2097152)) - 1048576;
            p.py = prior.py + $signed($urandom_range(2097152)) - 1048576;
            p.pz = prior.pz + $signed($urandom_range(2097152)) - 1048576;
            half = $urandom_range(31415) / 20000.0;
            ux = $urandom_range(2000) - 1000.0;
            uy = $urandom_range(2000) - 1000.0;
            uz = $urandom_range(2000) - 1000.0;
            un = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0e-6;
            s  = $sin(half) * 32767.0 / un;
            p.qx = 16'($rtoi(ux * s));
            p.qy = 16'($rtoi(uy * s));
            p.qz = 16'($rtoi(uz * s));
            p.qw = 16'($rtoi($cos(half) * 32767.0));
            if ($urandom_range(1)) p.qw = -p.qw;
         end
         return p;
      end
   endfunction

   row_type rows[8];

   initial begin
      pose_type   p;
      bit         made;
      motion_type m;
      int         keeps[5]   = '{1, 15, 0, 2, 7};
      int         idles[5]   = '{0, 85, 0, 32, 0};
      int         stalls[5]  = '{0, 0, 85, 32, 0};
      int         counts[5]  = '{200, 152, 200, 150, 150};

      axis_x = 0; axis_y = 0; axis_z = 0;
      last_x = 0; last_y = 0; last_z = 0;
      seen_pose = 1'b0;
      keep_phase = 0;
      keep_period_reg = KEEP_RESET;

      // Directed rows: identity, a 3-4-5 step, half turn, extremes, a quarter turn.
      rows[0] = '{'{0, 0, 0, 0, 0, 0, 0, 32767}, 1, 1, 0};
      rows[1] = '{'{1, 3 << 16, 4 << 16, 0, 0, 0, 0, 32767}, 1, 1, 5 << 16};
      rows[2] = '{'{2, 3 << 16, 4 << 16, 0, 32767, 0, 0, 0}, 1, 1, 0};
      rows[3] = '{'{3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, 0, 0};
      rows[4] = '{'{4, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1, 1, 32'hFFFF_FFFF};
      rows[5] = '{'{31'h7FFF_FFFF, 0, 0, 0, 23170, 0, 0, 23170}, 0, 0, 0};
      rows[6] = '{'{6, 0, 0, 0, 0, 23170, 0, -23170}, 0, 0, 0};
      rows[7] = '{'{7, -1, -1, -1, 0, 0, 32767, 0}, 0, 0, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset period of three is exercised first, then every pose is kept.
      for (int r = 0; r < 3; r++) begin
         send_pose(rows[r].pose, made, m);
      end
      write_keep(1);
      for (int r = 0; r < 8; r++) begin
         send_pose(rows[r].pose, made, m);
         if (rows[r].has_fixed) begin
            if (made != rows[r].fixed_out)
               report("directed result presence", made, rows[r].fixed_out);
            else if (made && m.step_len !== rows[r].fixed_dist)
               report("directed step distance", m.step_len, rows[r].fixed_dist);
         end
      end

      // Random phases across keep periods and flow control.
      p = rows[7].pose;
      for (int ph = 0; ph < 5; ph++) begin
         write_keep((ph == 4) ? 4'($urandom_range(15)) : 4'(keeps[ph]));
         send_idle_pct  = idles[ph];
         recv_stall_pct = stalls[ph];
         for (int n = 0; n < counts[ph]; n++) begin
            // Hold the sender until the block has drained, once per phase.
            if (n == counts[ph] / 2) begin
               req_tvalid <= 1'b0;
               drain_results();
            end
            p = random_pose(p);
            send_pose(p, made, m);
         end
      end
      req_tvalid <= 1'b0;

      // Last phase: no new poses, and the receiver stalls at random while the block drains.
      send_idle_pct  = 32;
      recv_stall_pct = 32;
      drain_results();

      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #40000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
